/* design/efd_pkg.sv */
// Shared types and codes for the escaped frame deframer.
// Frame phase encoding, result event codes, error codes and register indexes.
// No dependencies.
`default_nettype none

package efd_pkg;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_CODE   = 4'b0010,
		PH_PARAMS = 4'b0100,
		PH_ESC    = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		EV_PARAM    = 2'd0,
		EV_COMPLETE = 2'd1,
		EV_ERROR    = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		ERR_NONE          = 2'd0,
		ERR_BEGIN_MISSING = 2'd1,
		ERR_INCOMPLETE    = 2'd2,
		ERR_OVERFLOW      = 2'd3
	} error_t;

	localparam logic [1:0] REG_BEGIN_MARKER  = 2'd0;
	localparam logic [1:0] REG_END_MARKER    = 2'd1;
	localparam logic [1:0] REG_ESCAPE_MARKER = 2'd2;
	localparam logic [1:0] REG_ESCAPE_OFFSET = 2'd3;

	localparam logic [7:0] RST_BEGIN_MARKER  = 8'd255;
	localparam logic [7:0] RST_END_MARKER    = 8'd254;
	localparam logic [7:0] RST_ESCAPE_MARKER = 8'd253;
	localparam logic [7:0] RST_ESCAPE_OFFSET = 8'd3;

	// One decoded result request, before the output register.
	typedef struct packed {
		logic       valid;
		event_t     ev;
		logic [7:0] param_byte;
		logic [5:0] param_index;
		logic [7:0] frame_code;
		logic [6:0] param_count;
		error_t     error_code;
	} result_t;

endpackage

`default_nettype wire

/* design/escaped_frame_deframer_unit.sv */
// Escaped frame deframer: byte-stuffed frame decoder with one input register
// and one result register. Depends on efd_pkg.
//
// channel | handshake          | payload
// --------+--------------------+---------------------------------------------
// in      | in_valid/in_stall  | rx_byte, buffer_last
// out     | out_valid/out_stall| event_res, param_byte, param_index,
//         |                    | frame_code, param_count, error_code
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte per cycle sustained while no stalled result holds the input; a
// byte's result passes from the input register through decode into the result
// register.
// A full result register that is stalled holds the input register only when
// the byte there produces a result; bytes that produce none keep flowing.
// arst_n clears phase, code, counter, valid flags and loads register defaults.
// cfg_ready is always high.
`default_nettype none

module escaped_frame_deframer_unit
	import efd_pkg::*;
#(
	parameter int MAX_PARAMS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       buffer_last,

	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      event_res,
	output logic [7:0]      param_byte,
	output logic [5:0]      param_index,
	output logic [7:0]      frame_code,
	output logic [6:0]      param_count,
	output logic [1:0]      error_code,

	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int CW = $clog2(MAX_PARAMS + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARAMS);

	logic [7:0] begin_marker_q, end_marker_q, escape_marker_q, escape_offset_q;

	phase_t        phase_q, phase_nxt;
	logic [7:0]    held_code_q, held_code_nxt;
	logic [CW-1:0] counter_q, counter_nxt;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	result_t res;
	result_t out_q;
	logic    advance;
	logic [XW-1:0] cnt_ext;
	logic [7:0]    esc_val;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_marker_q  <= RST_BEGIN_MARKER;
			end_marker_q    <= RST_END_MARKER;
			escape_marker_q <= RST_ESCAPE_MARKER;
			escape_offset_q <= RST_ESCAPE_OFFSET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BEGIN_MARKER:  begin_marker_q  <= cfg_data;
				REG_END_MARKER:    end_marker_q    <= cfg_data;
				REG_ESCAPE_MARKER: escape_marker_q <= cfg_data;
				REG_ESCAPE_OFFSET: escape_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			last_s1 <= buffer_last;
		end
	end

	// Decode
	assign cnt_ext = XW'(counter_q);
	assign esc_val = byte_s1 - escape_offset_q;

	always_comb begin
		phase_nxt     = phase_q;
		held_code_nxt = held_code_q;
		counter_nxt   = counter_q;
		res           = '0;
		res.ev        = EV_PARAM;
		res.error_code = ERR_NONE;

		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 != begin_marker_q) begin
					res.valid      = 1'b1;
					res.ev         = EV_ERROR;
					res.error_code = ERR_BEGIN_MISSING;
				end else if (last_s1) begin
					res.valid      = 1'b1;
					res.ev         = EV_ERROR;
					res.error_code = ERR_INCOMPLETE;
				end else begin
					phase_nxt = PH_CODE;
				end
			end
			PH_CODE: begin
				if (last_s1) begin
					res.valid      = 1'b1;
					res.ev         = EV_ERROR;
					res.error_code = ERR_INCOMPLETE;
					phase_nxt      = PH_HUNT;
				end else begin
					held_code_nxt = byte_s1;
					counter_nxt   = '0;
					phase_nxt     = PH_PARAMS;
				end
			end
			PH_PARAMS, PH_ESC: begin
				res.frame_code = held_code_q;
				if (phase_q == PH_PARAMS && byte_s1 == end_marker_q) begin
					res.valid       = 1'b1;
					res.ev          = EV_COMPLETE;
					res.param_count = cnt_ext[6:0];
					phase_nxt       = PH_HUNT;
				end else if (last_s1) begin
					res.valid      = 1'b1;
					res.ev         = EV_ERROR;
					res.error_code = ERR_INCOMPLETE;
					phase_nxt      = PH_HUNT;
				end else if (phase_q == PH_PARAMS && byte_s1 == begin_marker_q) begin
					// aborted frame; this begin marker opens the next one
					res.valid      = 1'b1;
					res.ev         = EV_ERROR;
					res.error_code = ERR_INCOMPLETE;
					phase_nxt      = PH_CODE;
				end else if (phase_q == PH_PARAMS && byte_s1 == escape_marker_q) begin
					phase_nxt = PH_ESC;
				end else if (counter_q == CNT_MAX) begin
					res.valid      = 1'b1;
					res.ev         = EV_ERROR;
					res.error_code = ERR_OVERFLOW;
					phase_nxt      = PH_HUNT;
				end else begin
					res.valid       = 1'b1;
					res.ev          = EV_PARAM;
					res.param_byte  = (phase_q == PH_ESC) ? esc_val : byte_s1;
					res.param_index = cnt_ext[5:0];
					counter_nxt     = counter_q + 1'b1;
					phase_nxt       = PH_PARAMS;
				end
			end
			default: begin
				phase_nxt = PH_HUNT;
			end
		endcase
	end

	assign advance = valid_s1 && (!res.valid || !out_q.valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			held_code_q <= '0;
			counter_q   <= '0;
		end else if (advance) begin
			phase_q     <= phase_nxt;
			held_code_q <= held_code_nxt;
			counter_q   <= counter_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance && res.valid) begin
			out_q <= res;
		end else if (out_q.valid && !out_stall) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid   = out_q.valid;
	assign event_res   = out_q.ev;
	assign param_byte  = out_q.param_byte;
	assign param_index = out_q.param_index;
	assign frame_code  = out_q.frame_code;
	assign param_count = out_q.param_count;
	assign error_code  = out_q.error_code;

endmodule

`default_nettype wire

/* verif/efd_checker.sv */
// Scoreboard for the escaped frame deframer: shadows the marker registers,
// predicts the result of each accepted byte and compares accepted results.
// Depends on efd_pkg.
`timescale 1ns / 1ps

module efd_checker
	import efd_pkg::*;
#(
	parameter int MAX_PARAMS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       buffer_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] event_res,
	input  logic [7:0] param_byte,
	input  logic [5:0] param_index,
	input  logic [7:0] frame_code,
	input  logic [6:0] param_count,
	input  logic [1:0] error_code,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending,
	output int         results_seen,
	output int         frames_done,
	output int         errors_seen
);

	typedef struct {
		event_t     ev;
		logic [7:0] pbyte;
		logic [5:0] pindex;
		logic [7:0] code;
		logic [6:0] count;
		error_t     err;
	} frame_result_t;

	frame_result_t expected_q[$];
	frame_result_t next_result;
	frame_result_t want;

	logic [7:0] reg_begin, reg_end, reg_esc, reg_off;
	phase_t     ph;
	logic [7:0] held_code;
	int         held_count;

	// An error drops the deframer back to hunting; deframe_byte then moves an aborted frame to the code phase.
	function automatic frame_result_t error_result(logic [7:0] code, error_t err);
		frame_result_t r;
		r.ev = EV_ERROR;
		r.pbyte = '0;
		r.pindex = '0;
		r.code = code;
		r.count = '0;
		r.err = err;
		ph = PH_HUNT;
		return r;
	endfunction

	function automatic frame_result_t accept_param(logic [7:0] value);
		frame_result_t r;
		if (held_count >= MAX_PARAMS)
			return error_result(held_code, ERR_OVERFLOW);
		r.ev = EV_PARAM;
		r.pbyte = value;
		r.pindex = held_count[5:0];
		r.code = held_code;
		r.count = '0;
		r.err = ERR_NONE;
		held_count++;
		ph = PH_PARAMS;
		return r;
	endfunction

	// Returns 1 when the byte produces a result.
	function automatic bit deframe_byte(input logic [7:0] b, input logic is_last,
			output frame_result_t r);
		case (ph)
			PH_HUNT: begin
				if (b != reg_begin) begin
					r = error_result(8'h00, ERR_BEGIN_MISSING);
					return 1'b1;
				end
				if (is_last) begin
					r = error_result(8'h00, ERR_INCOMPLETE);
					return 1'b1;
				end
				ph = PH_CODE;
				return 1'b0;
			end
			PH_CODE: begin
				if (is_last) begin
					r = error_result(8'h00, ERR_INCOMPLETE);
					return 1'b1;
				end
				held_code = b;
				held_count = 0;
				ph = PH_PARAMS;
				return 1'b0;
			end
			PH_PARAMS: begin
				// end wins over begin, begin over escape
				if (b == reg_end) begin
					r.ev = EV_COMPLETE;
					r.pbyte = '0;
					r.pindex = '0;
					r.code = held_code;
					r.count = held_count[6:0];
					r.err = ERR_NONE;
					ph = PH_HUNT;
					return 1'b1;
				end
				if (is_last) begin
					r = error_result(held_code, ERR_INCOMPLETE);
					return 1'b1;
				end
				if (b == reg_begin) begin
					r = error_result(held_code, ERR_INCOMPLETE);
					ph = PH_CODE;
					return 1'b1;
				end
				if (b == reg_esc) begin
					ph = PH_ESC;
					return 1'b0;
				end
				r = accept_param(b);
				return 1'b1;
			end
			PH_ESC: begin
				if (is_last) begin
					r = error_result(held_code, ERR_INCOMPLETE);
					return 1'b1;
				end
				r = accept_param(8'(b - reg_off));
				return 1'b1;
			end
			default: begin
				ph = PH_HUNT;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_begin = RST_BEGIN_MARKER;
			reg_end = RST_END_MARKER;
			reg_esc = RST_ESCAPE_MARKER;
			reg_off = RST_ESCAPE_OFFSET;
			ph = PH_HUNT;
			held_code = '0;
			held_count = 0;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			frames_done = 0;
			errors_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BEGIN_MARKER:  reg_begin = cfg_data;
					REG_END_MARKER:    reg_end = cfg_data;
					REG_ESCAPE_MARKER: reg_esc = cfg_data;
					REG_ESCAPE_OFFSET: reg_off = cfg_data;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					$error("result with none expected: event %0d code %0d error %0d",
						event_res, frame_code, error_code);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (want.ev == EV_COMPLETE) frames_done++;
					if (want.ev == EV_ERROR) errors_seen++;
					check_field("event_res", want.ev, event_res);
					check_field("param_byte", want.pbyte, param_byte);
					check_field("param_index", want.pindex, param_index);
					check_field("frame_code", want.code, frame_code);
					check_field("param_count", want.count, param_count);
					check_field("error_code", want.err, error_code);
				end
			end
			if (in_valid && !in_stall) begin
				if (deframe_byte(rx_byte, buffer_last, next_result))
					expected_q.push_back(next_result);
			end
			pending = expected_q.size();
		end
	end

endmodule

/* verif/tb_top.sv */
// Testbench top for escaped_frame_deframer_unit: clock, reset, byte and
// register stimulus with random gaps and stalls, and the final verdict.
// Depends on efd_pkg, escaped_frame_deframer_unit and efd_checker.
`timescale 1ns / 1ps

module tb_top;
	import efd_pkg::*;

	localparam int MAX_PARAMS = 64;
	localparam int LIMIT = 200000;
	localparam int PHASE_BYTES = 240;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid, in_stall;
	logic [7:0] rx_byte;
	logic       buffer_last;
	logic       out_valid, out_stall;
	logic [1:0] event_res;
	logic [7:0] param_byte;
	logic [5:0] param_index;
	logic [7:0] frame_code;
	logic [6:0] param_count;
	logic [1:0] error_code;
	logic       cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	int fail_count, pending, results_seen, frames_done, errors_seen;

	int cycles = 0;
	int bytes_sent = 0;
	int settings_used = 1;
	int gap_pct = 20;
	int stall_pct = 20;
	int stall_left = 0;
	bit quiet_tail = 1'b0;

	logic [7:0] mk_begin = RST_BEGIN_MARKER;
	logic [7:0] mk_end = RST_END_MARKER;
	logic [7:0] mk_esc = RST_ESCAPE_MARKER;
	logic [7:0] mk_off = RST_ESCAPE_OFFSET;
	logic [7:0] frame_q[$];

	escaped_frame_deframer_unit #(.MAX_PARAMS(MAX_PARAMS)) u_top (.*);

	efd_checker #(.MAX_PARAMS(MAX_PARAMS)) u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[escaped_frame_deframer_unit] ERROR");
			$finish;
		end
	end

	// result side backpressure: out_stall in random bursts, started with probability stall_pct
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!out_stall && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic int pick_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the request
	// is taken.
	task automatic push_byte(input logic [7:0] b, input logic is_last);
		int gap;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		buffer_last <= is_last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Bytes with no result may still be in the pipe when the queue empties.
	task automatic drain();
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_markers(input logic [7:0] b, input logic [7:0] e,
			input logic [7:0] x, input logic [7:0] o);
		drain();
		cfg_write(REG_BEGIN_MARKER, b);
		cfg_write(REG_END_MARKER, e);
		cfg_write(REG_ESCAPE_MARKER, x);
		cfg_write(REG_ESCAPE_OFFSET, o);
		cfg_valid <= 1'b0;
		mk_begin = b;
		mk_end = e;
		mk_esc = x;
		mk_off = o;
		settings_used++;
	endtask

	// Mostly well-formed frames; some junk bytes, cut-short, aborted and overlong frames.
	task automatic send_mixed();
		int kind, n, stop;
		logic [7:0] v;
		if (!quiet_tail) begin
			gap_pct = pick_rate();
			stall_pct = pick_rate();
		end
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			push_byte(8'($urandom), $urandom_range(0, 7) == 0);
			return;
		end
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 8);
		frame_q.delete();
		frame_q.push_back(mk_begin);
		frame_q.push_back(8'($urandom));
		repeat (n) begin
			v = 8'($urandom);
			if (v == mk_begin || v == mk_end || v == mk_esc || $urandom_range(0, 7) == 0) begin
				frame_q.push_back(mk_esc);
				frame_q.push_back(8'(v + mk_off));
			end else begin
				frame_q.push_back(v);
			end
		end
		frame_q.push_back(mk_end);
		stop = frame_q.size() - 1;
		if (kind == 1)
			stop = $urandom_range(0, frame_q.size() - 1);
		else if (kind == 2)
			frame_q.insert($urandom_range(2, frame_q.size() - 1), mk_begin);
		if (kind == 2)
			stop = frame_q.size() - 1;
		for (int i = 0; i <= stop; i++)
			push_byte(frame_q[i], (i == stop) && (kind == 1 || $urandom_range(0, 3) == 0));
	endtask

	task automatic run_random(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count)
			send_mixed();
	endtask

	initial begin
		logic [7:0] rb, re, rx;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		buffer_last = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BEGIN_MARKER;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, power-on markers: begin FF, end FE, escape FD, offset 3
		push_byte(8'h00, 1'b0);		// no begin while hunting
		push_byte(8'hFF, 1'b1);		// begin as last byte
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFE, 1'b0);		// marker value as code
		push_byte(8'h00, 1'b0);
		push_byte(8'hFD, 1'b0);
		push_byte(8'h02, 1'b0);		// escaped, wraps to FF
		push_byte(8'hFE, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);		// begin as code
		push_byte(8'h7F, 1'b0);
		push_byte(8'hFF, 1'b0);		// bare begin aborts, new frame
		push_byte(8'h55, 1'b1);		// code byte is last
		push_byte(8'hFF, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte(8'hFD, 1'b0);
		push_byte(8'hFE, 1'b0);		// escaped end marker is a parameter, FB
		push_byte(8'hFD, 1'b1);		// escape as last byte
		push_byte(8'hFF, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'hFE, 1'b1);		// empty frame, end as last byte
		push_byte(8'hFF, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h80, 1'b1);		// parameter as last byte
		push_byte(8'hFF, 1'b0);
		push_byte(8'hBB, 1'b0);
		push_byte(8'hFD, 1'b0);
		push_byte(8'h10, 1'b1);		// escaped byte as last
		run_random(PHASE_BYTES);

		program_markers(8'h00, 8'h00, 8'h00, 8'h00);
		run_random(PHASE_BYTES);
		program_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_random(PHASE_BYTES);
		program_markers(8'h00, 8'h01, 8'h02, 8'hFF);
		run_random(PHASE_BYTES);

		rb = 8'($urandom);
		do re = 8'($urandom); while (re == rb);
		do rx = 8'($urandom); while (rx == rb || rx == re);
		program_markers(rb, re, rx, 8'($urandom));
		run_random(PHASE_BYTES);

		program_markers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		quiet_tail = 1'b1;
		gap_pct = 0;
		stall_pct = 0;
		run_random(PHASE_BYTES);

		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		$display("%0d bytes under %0d marker settings, %0d results checked",
			bytes_sent, settings_used, results_seen);
		$display("(%0d frames completed, %0d errors reported)", frames_done, errors_seen);
		if (fail_count == 0 && pending == 0)
			$display("[escaped_frame_deframer_unit] OK");
		else
			$display("[escaped_frame_deframer_unit] ERROR");
		$finish;
	end

endmodule
